/* src/dccu_pkg.sv */
`timescale 1ns / 1ps

package dccu_pkg;

    // Q2.30 working format of the cosine datapath
    localparam int unsigned FRAC_W   = 30;
    localparam int unsigned MAG_W    = 30;
    localparam int unsigned TERM_W   = 31;
    localparam int unsigned COS_W    = 32;
    localparam int unsigned ENERGY_W = 40;

    localparam logic [TERM_W-1:0]       ONE_Q30     = 31'h4000_0000;
    localparam logic signed [COS_W-1:0] COS_POS_ONE = 32'sh4000_0000;
    localparam logic signed [COS_W-1:0] COS_NEG_ONE = -32'sh4000_0000;

    // round(2^35/pi) = 10937044409, split in two 17-bit halves
    localparam logic signed [17:0] TURN_K_LO  = 18'sd3513;
    localparam logic signed [17:0] TURN_K_HI  = 18'sd83443;
    localparam int unsigned        TURN_K_SPLIT = 17;

    // pi/2 in Q1.32 (scaled by 2^32)
    localparam logic [32:0] PI_HALF_Q32 = 33'd6746518852;

    // Series terms. Division by k is a multiply by ceil(2^s/k) and a shift by s,
    // with s = 30 + ceil(log2 k); exact for numerators below 2^30.
    localparam int unsigned NUM_TERMS = 5;

    // cosine divisors 90, 56, 30, 12, 2
    localparam logic [30:0] COS_MAGIC [NUM_TERMS] = '{
        31'd1527099484, 31'd1227133514, 31'd1145324613, 31'd1431655766, 31'd1073741824
    };
    localparam int unsigned COS_SHIFT [NUM_TERMS] = '{37, 36, 35, 34, 31};
    localparam logic [5:0]  COS_HALF  [NUM_TERMS] = '{6'd45, 6'd28, 6'd15, 6'd6, 6'd1};

    // sine divisors 110, 72, 42, 20, 6
    localparam logic [30:0] SIN_MAGIC [NUM_TERMS] = '{
        31'd1249445032, 31'd1908874354, 31'd1636178018, 31'd1717986919, 31'd1431655766
    };
    localparam int unsigned SIN_SHIFT [NUM_TERMS] = '{37, 37, 36, 35, 33};
    localparam logic [5:0]  SIN_HALF  [NUM_TERMS] = '{6'd55, 6'd36, 6'd21, 6'd10, 6'd3};

    // pipeline depths
    localparam int unsigned PHASE_DEPTH       = 6;
    localparam int unsigned SERIES_STEP_DEPTH = 2;
    localparam int unsigned COS_DEPTH         = NUM_TERMS * SERIES_STEP_DEPTH + 2;
    localparam int unsigned HORNER_STEP_DEPTH = 2;
    localparam int unsigned HORNER_STEPS      = 3;

    // quadrant of the phase: which function and sign gives the cosine
    typedef enum logic [1:0] {
        QUAD_COS     = 2'd0,
        QUAD_NEG_SIN = 2'd1,
        QUAD_NEG_COS = 2'd2,
        QUAD_SIN     = 2'd3
    } quad_t;

    // reduced argument: quadrant, sign and magnitude of the residue
    typedef struct packed {
        quad_t            quad;
        logic             neg;
        logic [MAG_W-1:0] mag;
    } arg_t;

endpackage

/* src/dccu_phase.sv */
`timescale 1ns / 1ps

module dccu_phase #(
    parameter int unsigned ANGLE_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [ANGLE_WIDTH-1:0]     angle,
    output logic [dccu_pkg::MAG_W-1:0]        y_out,
    output dccu_pkg::arg_t                    arg_out
);

    localparam int unsigned PW = ANGLE_WIDTH + 18;
    localparam logic [62:0] RND_X  = 63'd1 << 31;
    localparam logic [59:0] RND_SQ = 60'd1 << 29;

    logic signed [PW-1:0]        plo_reg;
    logic signed [PW-1:0]        phi_reg;
    dccu_pkg::arg_t              arg1_reg;
    dccu_pkg::arg_t              arg2_reg;
    dccu_pkg::arg_t              arg3_reg;
    dccu_pkg::arg_t              arg4_reg;
    dccu_pkg::arg_t              arg5_reg;
    logic [62:0]                 xprod_reg;
    logic [59:0]                 sq_reg;
    logic [dccu_pkg::MAG_W-1:0]  y_reg;

    logic [63:0]                 turn_acc;
    logic [31:0]                 phase;
    logic [1:0]                  quad_sum;
    dccu_pkg::arg_t              arg1_next;
    dccu_pkg::arg_t              arg3_next;

    // phase in 2^-32 turn is bits 63:32 of angle * K, modulo 2^64
    always_comb
    begin
        turn_acc = 64'(plo_reg) + (64'(phi_reg) << dccu_pkg::TURN_K_SPLIT);
        phase    = turn_acc[63:32];
        quad_sum = phase[31:30] + {1'b0, phase[29]};
        arg1_next.quad = dccu_pkg::quad_t'(quad_sum);
        arg1_next.neg  = phase[29];
        arg1_next.mag  = phase[29] ? (30'd0 - phase[29:0]) : phase[29:0];
    end

    // residue to radians, rounded
    always_comb
    begin
        arg3_next     = arg2_reg;
        arg3_next.mag = 30'((xprod_reg + RND_X) >> 32);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            plo_reg   <= angle * dccu_pkg::TURN_K_LO;
            phi_reg   <= angle * dccu_pkg::TURN_K_HI;
            arg1_reg  <= arg1_next;
            xprod_reg <= arg1_reg.mag * dccu_pkg::PI_HALF_Q32;
            arg2_reg  <= arg1_reg;
            arg3_reg  <= arg3_next;
            sq_reg    <= arg3_reg.mag * arg3_reg.mag;
            arg4_reg  <= arg3_reg;
            y_reg     <= 30'((sq_reg + RND_SQ) >> dccu_pkg::FRAC_W);
            arg5_reg  <= arg4_reg;
        end
    end

    assign y_out   = y_reg;
    assign arg_out = arg5_reg;

endmodule

/* src/dccu_series_step.sv */
`timescale 1ns / 1ps

module dccu_series_step #(
    parameter int unsigned TERM = 0
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [dccu_pkg::MAG_W-1:0]    y_in,
    input  logic [dccu_pkg::TERM_W-1:0]   cos_t_in,
    input  logic [dccu_pkg::TERM_W-1:0]   sin_t_in,
    output logic [dccu_pkg::MAG_W-1:0]    y_out,
    output logic [dccu_pkg::TERM_W-1:0]   cos_t_out,
    output logic [dccu_pkg::TERM_W-1:0]   sin_t_out
);

    localparam logic [60:0] RND = 61'd1 << 29;

    logic [60:0]                   cprod_reg;
    logic [60:0]                   sprod_reg;
    logic [dccu_pkg::MAG_W-1:0]    y_a_reg;
    logic [61:0]                   cquot_reg;
    logic [61:0]                   squot_reg;
    logic [dccu_pkg::MAG_W-1:0]    y_b_reg;

    logic [30:0]                   cnum;
    logic [30:0]                   snum;

    // round y*t to Q2.30, add k/2 for the rounded divide
    always_comb
    begin
        cnum = 31'((cprod_reg + RND) >> dccu_pkg::FRAC_W)
               + 31'(dccu_pkg::COS_HALF[TERM]);
        snum = 31'((sprod_reg + RND) >> dccu_pkg::FRAC_W)
               + 31'(dccu_pkg::SIN_HALF[TERM]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cprod_reg <= y_in * cos_t_in;
            sprod_reg <= y_in * sin_t_in;
            y_a_reg   <= y_in;
            cquot_reg <= cnum * dccu_pkg::COS_MAGIC[TERM];
            squot_reg <= snum * dccu_pkg::SIN_MAGIC[TERM];
            y_b_reg   <= y_a_reg;
        end
    end

    assign y_out     = y_b_reg;
    assign cos_t_out = dccu_pkg::ONE_Q30 - 31'(cquot_reg >> dccu_pkg::COS_SHIFT[TERM]);
    assign sin_t_out = dccu_pkg::ONE_Q30 - 31'(squot_reg >> dccu_pkg::SIN_SHIFT[TERM]);

endmodule

/* src/dccu_cosine.sv */
`timescale 1ns / 1ps

module dccu_cosine (
    input  logic                                clk,
    input  logic                                en,
    input  logic [dccu_pkg::MAG_W-1:0]          y_in,
    input  dccu_pkg::arg_t                      arg_in,
    output logic signed [dccu_pkg::COS_W-1:0]   cos_out
);

    localparam int unsigned SERIES_LAT = dccu_pkg::NUM_TERMS * dccu_pkg::SERIES_STEP_DEPTH;
    localparam logic [60:0] RND = 61'd1 << 29;

    logic [dccu_pkg::MAG_W-1:0]           y_link     [dccu_pkg::NUM_TERMS+1];
    logic [dccu_pkg::TERM_W-1:0]          cos_t_link [dccu_pkg::NUM_TERMS+1];
    logic [dccu_pkg::TERM_W-1:0]          sin_t_link [dccu_pkg::NUM_TERMS+1];

    dccu_pkg::arg_t                       arg_dly_reg [SERIES_LAT];
    dccu_pkg::arg_t                       arg_a_reg;
    logic [60:0]                          sprod_reg;
    logic [dccu_pkg::TERM_W-1:0]          cval_reg;
    logic signed [dccu_pkg::COS_W-1:0]    cos_reg;

    logic [30:0]                          smag;
    logic signed [dccu_pkg::COS_W-1:0]    sin_s;
    logic signed [dccu_pkg::COS_W-1:0]    cos_s;
    logic signed [dccu_pkg::COS_W-1:0]    pick;
    logic signed [dccu_pkg::COS_W-1:0]    cos_next;

    assign y_link[0]     = y_in;
    assign cos_t_link[0] = dccu_pkg::ONE_Q30;
    assign sin_t_link[0] = dccu_pkg::ONE_Q30;

    for (genvar i = 0; i < dccu_pkg::NUM_TERMS; i++)
    begin : g_term
        dccu_series_step #(
            .TERM (i)
        ) u_step (
            .clk       (clk),
            .en        (en),
            .y_in      (y_link[i]),
            .cos_t_in  (cos_t_link[i]),
            .sin_t_in  (sin_t_link[i]),
            .y_out     (y_link[i+1]),
            .cos_t_out (cos_t_link[i+1]),
            .sin_t_out (sin_t_link[i+1])
        );
    end

    // sin x = x*u, then pick by quadrant and clamp to [-1, 1]
    always_comb
    begin
        smag  = 31'((sprod_reg + RND) >> dccu_pkg::FRAC_W);
        sin_s = arg_a_reg.neg ? -signed'(32'(smag)) : signed'(32'(smag));
        cos_s = signed'(32'(cval_reg));
        unique case (arg_a_reg.quad)
            dccu_pkg::QUAD_COS:     pick = cos_s;
            dccu_pkg::QUAD_NEG_SIN: pick = -sin_s;
            dccu_pkg::QUAD_NEG_COS: pick = -cos_s;
            dccu_pkg::QUAD_SIN:     pick = sin_s;
            default:                pick = cos_s;
        endcase
        priority if (pick > dccu_pkg::COS_POS_ONE)
            cos_next = dccu_pkg::COS_POS_ONE;
        else if (pick < dccu_pkg::COS_NEG_ONE)
            cos_next = dccu_pkg::COS_NEG_ONE;
        else
            cos_next = pick;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            arg_dly_reg[0] <= arg_in;
            for (int i = 1; i < SERIES_LAT; i++)
            begin
                arg_dly_reg[i] <= arg_dly_reg[i-1];
            end
            arg_a_reg <= arg_dly_reg[SERIES_LAT-1];
            sprod_reg <= arg_dly_reg[SERIES_LAT-1].mag * sin_t_link[dccu_pkg::NUM_TERMS];
            cval_reg  <= cos_t_link[dccu_pkg::NUM_TERMS];
            cos_reg   <= cos_next;
        end
    end

    assign cos_out = cos_reg;

endmodule

/* src/dccu_horner_step.sv */
`timescale 1ns / 1ps

module dccu_horner_step #(
    parameter int unsigned E_W = 32,
    parameter int unsigned C_W = 32
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [E_W-1:0]               e_in,
    input  logic signed [C_W-1:0]               add_in,
    input  logic signed [dccu_pkg::COS_W-1:0]   cos_in,
    output logic signed [E_W:0]                 e_out,
    output logic signed [dccu_pkg::COS_W-1:0]   cos_out
);

    localparam int unsigned OUT_W  = E_W + 1;
    localparam int unsigned PROD_W = E_W + 31;
    localparam logic [PROD_W-1:0] RND = PROD_W'(1) << 29;

    logic [PROD_W-1:0]                    prod_reg;
    logic                                 neg_reg;
    logic signed [C_W-1:0]                add_a_reg;
    logic signed [dccu_pkg::COS_W-1:0]    cos_a_reg;
    logic signed [OUT_W-1:0]              e_reg;
    logic signed [dccu_pkg::COS_W-1:0]    cos_b_reg;

    logic [E_W-1:0]                       emag;
    logic [dccu_pkg::COS_W-1:0]           cneg;
    logic [30:0]                          cmag;
    logic [E_W-1:0]                       rmag;
    logic signed [OUT_W-1:0]              rmag_s;
    logic signed [OUT_W-1:0]              e_next;

    // multiply magnitudes, round half away from zero
    always_comb
    begin
        emag   = e_in[E_W-1] ? E_W'(-e_in) : E_W'(e_in);
        cneg   = 32'd0 - cos_in;
        cmag   = cos_in[dccu_pkg::COS_W-1] ? cneg[30:0] : cos_in[30:0];
        rmag   = E_W'((prod_reg + RND) >> dccu_pkg::FRAC_W);
        rmag_s = signed'({1'b0, rmag});
        e_next = (neg_reg ? -rmag_s : rmag_s) + OUT_W'(add_a_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= emag * cmag;
            neg_reg   <= e_in[E_W-1] ^ cos_in[dccu_pkg::COS_W-1];
            add_a_reg <= add_in;
            cos_a_reg <= cos_in;
            e_reg     <= e_next;
            cos_b_reg <= cos_a_reg;
        end
    end

    assign e_out   = e_reg;
    assign cos_out = cos_b_reg;

endmodule

/* src/dihedral_cosine_cubic_energy_unit.sv */
`timescale 1ns / 1ps

// Ryckaert-Bellemans dihedral energy: each input word carries a dihedral angle
// (signed Q4.28 radians at the default width) and four Q16.16 coefficients, and
// yields one word E = c0 + c*(c1 + c*(c2 + c*c3)) in signed Q24.16, where c is
// the cosine of the angle in Q2.30. The angle is reduced modulo one turn, so any
// bit pattern is valid; the cosine comes from a quadrant fold and two short
// Taylor series (cosine and sine) evaluated in parallel, then Horner's rule
// gives the energy. The block is a 24-stage pipeline plus an output register:
// a word passes through the stages and the output register before out_valid
// shows it, and a new word can be accepted on every cycle for as long as the
// output side takes words. A two-entry output (register plus skid) separates
// the sides, so in_stall is registered and rises only after out_stall has held
// a waiting word.
module dihedral_cosine_cubic_energy_unit #(
    parameter int unsigned ANGLE_WIDTH = 32,
    parameter int unsigned COEF_WIDTH  = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [ANGLE_WIDTH-1:0]          angle,
    input  logic signed [COEF_WIDTH-1:0]           coef_zero,
    input  logic signed [COEF_WIDTH-1:0]           coef_one,
    input  logic signed [COEF_WIDTH-1:0]           coef_two,
    input  logic signed [COEF_WIDTH-1:0]           coef_three,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic signed [dccu_pkg::ENERGY_W-1:0]   energy_out
);

    localparam int unsigned EW       = dccu_pkg::ENERGY_W;
    localparam int unsigned COS_LAT  = dccu_pkg::PHASE_DEPTH + dccu_pkg::COS_DEPTH;
    localparam int unsigned COEF_LEN = COS_LAT
                                       + (dccu_pkg::HORNER_STEPS - 1)
                                       * dccu_pkg::HORNER_STEP_DEPTH;
    localparam int unsigned TOTAL    = COS_LAT
                                       + dccu_pkg::HORNER_STEPS
                                       * dccu_pkg::HORNER_STEP_DEPTH;

    typedef struct packed {
        logic signed [COEF_WIDTH-1:0] zero;
        logic signed [COEF_WIDTH-1:0] one;
        logic signed [COEF_WIDTH-1:0] two;
        logic signed [COEF_WIDTH-1:0] three;
    } coef_set_t;

    // pipeline control
    logic                                 en;
    logic [TOTAL-1:0]                     vld_reg;
    logic [TOTAL-1:0]                     vld_next;

    // coefficients ride beside the cosine datapath
    coef_set_t                            coef_line_reg [COEF_LEN];

    // datapath links
    logic [dccu_pkg::MAG_W-1:0]           y_ph;
    dccu_pkg::arg_t                       arg_ph;
    logic signed [dccu_pkg::COS_W-1:0]    cos_val;
    logic signed [COEF_WIDTH:0]           e_h1;
    logic signed [COEF_WIDTH+1:0]         e_h2;
    logic signed [COEF_WIDTH+2:0]         e_h3;
    logic signed [dccu_pkg::COS_W-1:0]    cos_h1;
    logic signed [dccu_pkg::COS_W-1:0]    cos_h2;
    logic signed [dccu_pkg::COS_W-1:0]    cos_h3;
    logic signed [EW-1:0]                 energy_fin;

    // output register and skid
    logic                                 out_valid_reg;
    logic                                 out_valid_next;
    logic signed [EW-1:0]                 out_data_reg;
    logic signed [EW-1:0]                 out_data_next;
    logic                                 skid_full_reg;
    logic                                 skid_full_next;
    logic signed [EW-1:0]                 skid_data_reg;
    logic signed [EW-1:0]                 skid_data_next;
    logic                                 out_take;
    logic                                 fin_valid;

    // Advance the whole pipeline unless the skid holds a word.
    assign en       = !skid_full_reg;
    assign in_stall = skid_full_reg;
    assign vld_next = {vld_reg[TOTAL-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            coef_line_reg[0] <= '{zero: coef_zero, one: coef_one,
                                  two: coef_two, three: coef_three};
            for (int i = 1; i < COEF_LEN; i++)
            begin
                coef_line_reg[i] <= coef_line_reg[i-1];
            end
        end
    end

    // Angle to reduced argument and its square.
    dccu_phase #(
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_phase (
        .clk     (clk),
        .en      (en),
        .angle   (angle),
        .y_out   (y_ph),
        .arg_out (arg_ph)
    );

    // Series evaluation, quadrant fold and clamp.
    dccu_cosine u_cosine (
        .clk     (clk),
        .en      (en),
        .y_in    (y_ph),
        .arg_in  (arg_ph),
        .cos_out (cos_val)
    );

    // Horner's rule: c3 -> c2 + e*c -> c1 + e*c -> c0 + e*c
    dccu_horner_step #(
        .E_W (COEF_WIDTH),
        .C_W (COEF_WIDTH)
    ) u_horner_two (
        .clk     (clk),
        .en      (en),
        .e_in    (coef_line_reg[COS_LAT-1].three),
        .add_in  (coef_line_reg[COS_LAT-1].two),
        .cos_in  (cos_val),
        .e_out   (e_h1),
        .cos_out (cos_h1)
    );

    dccu_horner_step #(
        .E_W (COEF_WIDTH + 1),
        .C_W (COEF_WIDTH)
    ) u_horner_one (
        .clk     (clk),
        .en      (en),
        .e_in    (e_h1),
        .add_in  (coef_line_reg[COS_LAT+dccu_pkg::HORNER_STEP_DEPTH-1].one),
        .cos_in  (cos_h1),
        .e_out   (e_h2),
        .cos_out (cos_h2)
    );

    dccu_horner_step #(
        .E_W (COEF_WIDTH + 2),
        .C_W (COEF_WIDTH)
    ) u_horner_zero (
        .clk     (clk),
        .en      (en),
        .e_in    (e_h2),
        .add_in  (coef_line_reg[COEF_LEN-1].zero),
        .cos_in  (cos_h2),
        .e_out   (e_h3),
        .cos_out (cos_h3)
    );

    // Wrap or sign-extend to the 40-bit result; the last cosine tap is spare.
    assign energy_fin = EW'(e_h3);
    assign fin_valid  = vld_reg[TOTAL-1] && (cos_h3 == cos_h3);

    // Output side: take from the skid first, otherwise from the pipeline.
    assign out_take = out_valid_reg && !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        skid_full_next = skid_full_reg;
        skid_data_next = skid_data_reg;
        priority if (skid_full_reg)
        begin
            if (out_take)
            begin
                out_data_next  = skid_data_reg;
                skid_full_next = 1'b0;
            end
        end
        else if (!out_valid_reg || out_take)
        begin
            out_valid_next = fin_valid;
            if (fin_valid)
            begin
                out_data_next = energy_fin;
            end
        end
        else if (fin_valid)
        begin
            // hold the output word, park the arriving one
            skid_full_next = 1'b1;
            skid_data_next = energy_fin;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign energy_out = out_data_reg;

endmodule

/* src/dccu_checker.sv */
`timescale 1ns / 1ps

module dccu_checker (
    input logic                                   clk,
    input logic                                   rst_n,
    input logic                                   in_stall,
    input logic                                   out_valid,
    input logic                                   out_stall,
    input logic signed [dccu_pkg::ENERGY_W-1:0]   energy_out
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(energy_out))
        else $error("output word changed while stalled");

    // input stalls only while an output word is waiting
    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with empty output");

    // the skid fills only behind a stalled output word
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(in_stall) |-> $past(out_valid && out_stall))
        else $error("input stall rose without output stall");

    // once the output word is taken, the skid drains
    a_stall_release: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall && !out_stall |=> !in_stall)
        else $error("input stall held after output was taken");

endmodule

bind dihedral_cosine_cubic_energy_unit dccu_checker u_dccu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .energy_out (energy_out)
);
